### design/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Shared widths, register indexes and reset values for the NEC IR decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int TICKS_W = 15;
  localparam int SCALE_W = 5;
  localparam int TARGET_W = 16;
  localparam int US_W = TICKS_W + SCALE_W;
  localparam int IDX_W = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int FIELD_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TICK_US      = 3'd0,
    REG_HEADER_MARK  = 3'd1,
    REG_HEADER_SPACE = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5
  } cfg_reg_t;

  localparam logic [SCALE_W-1:0]  RST_TICK_US      = 5'd1;
  localparam logic [TARGET_W-1:0] RST_HEADER_MARK  = 16'd9000;
  localparam logic [TARGET_W-1:0] RST_HEADER_SPACE = 16'd4500;
  localparam logic [TARGET_W-1:0] RST_BIT_MARK     = 16'd560;
  localparam logic [TARGET_W-1:0] RST_ZERO_SPACE   = 16'd560;
  localparam logic [TARGET_W-1:0] RST_ONE_SPACE    = 16'd1690;

endpackage

### design/necir_window.sv
// ----------------------------------------------------------------------------
// necir_window
// Strict 25 percent window match of a duration in microseconds to a target.
// ----------------------------------------------------------------------------
module necir_window (
  input  logic [necir_pkg::US_W-1:0]     us,
  input  logic [necir_pkg::TARGET_W-1:0] target,
  output logic                           match
);

  logic [necir_pkg::TARGET_W-1:0] slack;
  logic [necir_pkg::TARGET_W-1:0] lo;
  logic [necir_pkg::TARGET_W:0]   hi;

  assign slack = target >> 2;
  assign lo    = target - slack;
  assign hi    = {1'b0, target} + {1'b0, slack};
  assign match = (us > necir_pkg::US_W'(lo)) && (us < necir_pkg::US_W'(hi));

endmodule

### design/nec_ir_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// NEC IR frame decoder: checks one mark/space symbol per item, collects data
// bits and emits one result (ok, address, command) on the last symbol.
// Path: accepted item -> input register -> result register (out_tvalid, out_tdata, out_tuser).
// Throughput: one item per cycle, but a last symbol stalls while an earlier result is not taken.
// Reset: clears handshake and frame state, loads default register values.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core #(
  parameter int DATA_BITS   = 32,
  parameter int MIN_SYMBOLS = 34
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg port
  input  logic                               cfg_we,
  input  logic [necir_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [necir_pkg::TARGET_W-1:0]     cfg_wdata,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,  // mark_ticks[14:0], space_ticks[29:15]
  input  logic                               in_tuser,  // first_symbol
  input  logic                               in_tlast,  // last_symbol
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata, // address[15:0], command[31:16]
  output logic                               out_tuser  // decoded_ok
);

  localparam int INDEX_CAP = (MIN_SYMBOLS > DATA_BITS + 1) ? MIN_SYMBOLS : DATA_BITS + 1;
  localparam int TW = necir_pkg::TICKS_W;

  // configuration
  logic [necir_pkg::SCALE_W-1:0]  tick_us_r;
  logic [necir_pkg::TARGET_W-1:0] hdr_mark_r, hdr_space_r, bit_mark_r;
  logic [necir_pkg::TARGET_W-1:0] zero_space_r, one_space_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_us_r    <= necir_pkg::RST_TICK_US;
      hdr_mark_r   <= necir_pkg::RST_HEADER_MARK;
      hdr_space_r  <= necir_pkg::RST_HEADER_SPACE;
      bit_mark_r   <= necir_pkg::RST_BIT_MARK;
      zero_space_r <= necir_pkg::RST_ZERO_SPACE;
      one_space_r  <= necir_pkg::RST_ONE_SPACE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        necir_pkg::REG_TICK_US:      tick_us_r    <= cfg_wdata[necir_pkg::SCALE_W-1:0];
        necir_pkg::REG_HEADER_MARK:  hdr_mark_r   <= cfg_wdata;
        necir_pkg::REG_HEADER_SPACE: hdr_space_r  <= cfg_wdata;
        necir_pkg::REG_BIT_MARK:     bit_mark_r   <= cfg_wdata;
        necir_pkg::REG_ZERO_SPACE:   zero_space_r <= cfg_wdata;
        necir_pkg::REG_ONE_SPACE:    one_space_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic          in_valid_r;
  logic [TW-1:0] mark_r, space_r;
  logic          first_r, last_r;
  logic          advance;

  assign advance   = in_valid_r && (!last_r || !out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mark_r  <= in_tdata[TW-1:0];
      space_r <= in_tdata[2*TW-1:TW];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  // scaling and window checks
  logic [necir_pkg::US_W-1:0] mark_us, space_us;
  logic hdr_mark_ok, hdr_space_ok, bit_mark_ok, zero_ok, one_ok;

  assign mark_us  = necir_pkg::US_W'(mark_r) * necir_pkg::US_W'(tick_us_r);
  assign space_us = necir_pkg::US_W'(space_r) * necir_pkg::US_W'(tick_us_r);

  necir_window u_hdr_mark  (.us(mark_us),  .target(hdr_mark_r),   .match(hdr_mark_ok));
  necir_window u_hdr_space (.us(space_us), .target(hdr_space_r),  .match(hdr_space_ok));
  necir_window u_bit_mark  (.us(mark_us),  .target(bit_mark_r),   .match(bit_mark_ok));
  necir_window u_zero      (.us(space_us), .target(zero_space_r), .match(zero_ok));
  necir_window u_one       (.us(space_us), .target(one_space_r),  .match(one_ok));

  // frame state
  logic [necir_pkg::IDX_W-1:0] idx_r, idx_nxt, idx_cur, idx_inc;
  logic [DATA_BITS-1:0]        data_r, data_nxt, data_cur, data_upd;
  logic                        good_r, good_nxt, good_cur, good_upd;
  logic                        res_ok;
  logic [31:0]                 res_data;

  always_comb begin
    idx_cur  = first_r ? '0 : idx_r;
    data_cur = first_r ? '0 : data_r;
    good_cur = first_r ? 1'b1 : good_r;
    data_upd = data_cur;
    good_upd = good_cur;
    if (idx_cur == '0) begin
      if (!hdr_mark_ok || !hdr_space_ok) good_upd = 1'b0;
    end else if (idx_cur <= necir_pkg::IDX_W'(DATA_BITS)) begin
      if (!bit_mark_ok) begin
        good_upd = 1'b0;
      end else if (one_ok) begin
        for (int i = 0; i < DATA_BITS; i++) begin
          if (idx_cur == necir_pkg::IDX_W'(i + 1)) data_upd[i] = 1'b1;
        end
      end else if (!zero_ok) begin
        good_upd = 1'b0;
      end
    end
    idx_inc = (idx_cur < necir_pkg::IDX_W'(INDEX_CAP)) ? idx_cur + 1'b1 : idx_cur;
    res_ok  = good_upd && (idx_inc >= necir_pkg::IDX_W'(MIN_SYMBOLS));
    res_data = res_ok ? 32'(data_upd) : '0;
    if (last_r) begin
      idx_nxt  = '0;
      data_nxt = '0;
      good_nxt = 1'b1;
    end else begin
      idx_nxt  = idx_inc;
      data_nxt = data_upd;
      good_nxt = good_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      data_r <= '0;
      good_r <= 1'b1;
    end else if (advance) begin
      idx_r  <= idx_nxt;
      data_r <= data_nxt;
      good_r <= good_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (advance && last_r) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      out_tuser <= res_ok;
      out_tdata <= res_data;
    end
  end

endmodule

### tb/sv/nec_ir_frame_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core_tb
// Self-checking bench for the NEC IR frame decoder. Symbol items are queued
// per register setting, sent with random gaps and checked against a local
// frame decoder model. The output side stalls at random as well.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core_tb;

  localparam int DATA_BITS   = 32;
  localparam int MIN_SYMBOLS = 34;
  localparam int COUNT_CAP   = (MIN_SYMBOLS > DATA_BITS + 1) ? MIN_SYMBOLS : DATA_BITS + 1;
  localparam int MAX_TICKS   = (1 << necir_pkg::TICKS_W) - 1;

  typedef struct packed {
    logic [necir_pkg::TICKS_W-1:0] mark;
    logic [necir_pkg::TICKS_W-1:0] space;
    logic                          first;
    logic                          last;
  } symbol_t;

  typedef struct packed {
    logic                          ok;
    logic [necir_pkg::FIELD_W-1:0] address;
    logic [necir_pkg::FIELD_W-1:0] command;
  } frame_t;

  typedef enum int {DUR_FIT, DUR_BOUND, DUR_WILD} dur_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [necir_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [necir_pkg::TARGET_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;  // mark_ticks[14:0], space_ticks[29:15]
  logic in_tuser = 1'b0;       // first_symbol
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;      // address[15:0], command[31:16]
  logic out_tuser;             // decoded_ok

  // register copy
  logic [necir_pkg::SCALE_W-1:0]  tick_us    = necir_pkg::RST_TICK_US;
  logic [necir_pkg::TARGET_W-1:0] hdr_mark   = necir_pkg::RST_HEADER_MARK;
  logic [necir_pkg::TARGET_W-1:0] hdr_space  = necir_pkg::RST_HEADER_SPACE;
  logic [necir_pkg::TARGET_W-1:0] bit_mark   = necir_pkg::RST_BIT_MARK;
  logic [necir_pkg::TARGET_W-1:0] zero_space = necir_pkg::RST_ZERO_SPACE;
  logic [necir_pkg::TARGET_W-1:0] one_space  = necir_pkg::RST_ONE_SPACE;

  // decoder state copy
  logic [necir_pkg::IDX_W-1:0] sym_count = '0;
  logic [31:0]                 bits_seen = '0;
  logic                        frame_ok  = 1'b1;

  symbol_t symbols_q[$];
  frame_t  frames_expected[$];
  symbol_t cur_sym;
  int      gap_left = 0;
  int      stall_left = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      mismatches = 0;
  bit      prev_closed = 1'b1;

  nec_ir_frame_decoder_core #(
    .DATA_BITS(DATA_BITS),
    .MIN_SYMBOLS(MIN_SYMBOLS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  function automatic bit in_window(logic [necir_pkg::TICKS_W-1:0] ticks,
                                   logic [necir_pkg::TARGET_W-1:0] target);
    int unsigned us;
    int unsigned t;
    int unsigned slack;
    us = int'(ticks) * int'(tick_us);
    t = target;
    slack = t / 4;
    return (us > t - slack) && (us < t + slack);
  endfunction

  task automatic restart_frame();
    sym_count = '0;
    bits_seen = '0;
    frame_ok = 1'b1;
  endtask

  task automatic decode_symbol(symbol_t s);
    frame_t f;
    if (s.first) restart_frame();
    if (sym_count == 0) begin
      if (!in_window(s.mark, hdr_mark) || !in_window(s.space, hdr_space)) frame_ok = 1'b0;
    end else if (sym_count <= DATA_BITS) begin
      if (!in_window(s.mark, bit_mark)) frame_ok = 1'b0;
      else if (in_window(s.space, one_space)) bits_seen[sym_count - 1] = 1'b1;
      else if (!in_window(s.space, zero_space)) frame_ok = 1'b0;
    end
    if (sym_count < COUNT_CAP) sym_count = sym_count + 1'b1;
    if (s.last) begin
      f.ok = frame_ok && (sym_count >= MIN_SYMBOLS);
      f.address = f.ok ? bits_seen[15:0] : '0;
      f.command = f.ok ? bits_seen[31:16] : '0;
      frames_expected.push_back(f);
      restart_frame();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_symbol(cur_sym);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (symbols_q.size() != 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(16);
          in_tvalid <= 1'b0;
        end else if (symbols_q.size() != 0) begin
          cur_sym = symbols_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cur_sym.space, cur_sym.mark};
          in_tuser <= cur_sym.first;
          in_tlast <= cur_sym.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frames_expected.size() == 0) begin
          $display("%0t: unexpected result ok=%0b data=%h", $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = frames_expected.pop_front();
          if (out_tuser !== want.ok) begin
            $display("%0t: decoded_ok expected %0b actual %0b", $time, want.ok, out_tuser);
            mismatches++;
          end
          if (out_tdata[15:0] !== want.address) begin
            $display("%0t: address expected %h actual %h", $time, want.address,
                     out_tdata[15:0]);
            mismatches++;
          end
          if (out_tdata[31:16] !== want.command) begin
            $display("%0t: command expected %h actual %h", $time, want.command,
                     out_tdata[31:16]);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(16);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(necir_pkg::cfg_reg_t r, logic [necir_pkg::TARGET_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    case (r)
      necir_pkg::REG_TICK_US:      tick_us = v[necir_pkg::SCALE_W-1:0];
      necir_pkg::REG_HEADER_MARK:  hdr_mark = v;
      necir_pkg::REG_HEADER_SPACE: hdr_space = v;
      necir_pkg::REG_BIT_MARK:     bit_mark = v;
      necir_pkg::REG_ZERO_SPACE:   zero_space = v;
      necir_pkg::REG_ONE_SPACE:    one_space = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int tk, int hm, int hs, int bm, int zs, int os);
    write_reg(necir_pkg::REG_TICK_US, necir_pkg::TARGET_W'(tk));
    write_reg(necir_pkg::REG_HEADER_MARK, necir_pkg::TARGET_W'(hm));
    write_reg(necir_pkg::REG_HEADER_SPACE, necir_pkg::TARGET_W'(hs));
    write_reg(necir_pkg::REG_BIT_MARK, necir_pkg::TARGET_W'(bm));
    write_reg(necir_pkg::REG_ZERO_SPACE, necir_pkg::TARGET_W'(zs));
    write_reg(necir_pkg::REG_ONE_SPACE, necir_pkg::TARGET_W'(os));
  endtask

  task automatic wait_idle();
    while (symbols_q.size() != 0 || in_tvalid || frames_expected.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic push_symbol(int mark, int space, bit first, bit last, ref int added);
    symbol_t s;
    s.mark = necir_pkg::TICKS_W'(mark);
    s.space = necir_pkg::TICKS_W'(space);
    s.first = first;
    s.last = last;
    symbols_q.push_back(s);
    prev_closed = last;
    added++;
  endtask

  // duration in ticks that lands inside, on the rim of, or anywhere around a target
  function automatic int pick_ticks(logic [necir_pkg::TARGET_W-1:0] target, dur_mode_t mode);
    int unsigned tu;
    int unsigned slack;
    int lo;
    int hi;
    int pick;
    tu = tick_us;
    slack = target / 4;
    if (tu == 0 || target == 0 || mode == DUR_WILD) return $urandom_range(MAX_TICKS);
    lo = (target - slack) / tu + 1;
    hi = (target + slack + tu - 1) / tu - 1;
    if (mode == DUR_BOUND) begin
      case ($urandom_range(3))
        0: pick = lo - 1;
        1: pick = lo;
        2: pick = hi;
        default: pick = hi + 1;
      endcase
      return (pick < 0) ? 0 : (pick > MAX_TICKS) ? MAX_TICKS : pick;
    end
    if (lo > hi || lo > MAX_TICKS) return $urandom_range(MAX_TICKS);
    return $urandom_range(lo, (hi > MAX_TICKS) ? MAX_TICKS : hi);
  endfunction

  task automatic add_frame(int n_sym, int flaw_at, bit no_first, bit no_last, ref int added);
    logic [31:0] data;
    int r;
    int mark;
    int space;
    dur_mode_t mm;
    dur_mode_t sm;
    r = $urandom_range(99);
    data = (r < 10) ? 32'h0 : (r < 20) ? 32'hffff_ffff : $urandom;
    for (int s = 0; s < n_sym; s++) begin
      mm = DUR_FIT;
      sm = DUR_FIT;
      if (s == flaw_at) begin
        if ($urandom_range(1)) mm = $urandom_range(1) ? DUR_BOUND : DUR_WILD;
        else sm = $urandom_range(1) ? DUR_BOUND : DUR_WILD;
      end
      if (s == 0) begin
        mark = pick_ticks(hdr_mark, mm);
        space = pick_ticks(hdr_space, sm);
      end else if (s <= DATA_BITS) begin
        mark = pick_ticks(bit_mark, mm);
        space = pick_ticks(data[s-1] ? one_space : zero_space, sm);
      end else begin
        mark = pick_ticks(bit_mark, DUR_WILD);
        space = pick_ticks(zero_space, DUR_WILD);
      end
      push_symbol(mark, space, (s == 0) && !no_first, (s == n_sym - 1) && !no_last, added);
    end
  endtask

  task automatic fill_phase(int budget);
    int added;
    int r;
    int n;
    added = 0;
    while (added < budget) begin
      r = $urandom_range(99);
      if (r < 65) begin
        n = ($urandom_range(4) != 0) ? MIN_SYMBOLS : $urandom_range(MIN_SYMBOLS + 1, 40);
        add_frame(n, -1, prev_closed && ($urandom_range(6) == 0), 1'b0, added);
      end else if (r < 80) begin
        add_frame(MIN_SYMBOLS, $urandom_range(MIN_SYMBOLS - 1), 1'b0, 1'b0, added);
      end else if (r < 87) begin
        add_frame($urandom_range(2, MIN_SYMBOLS - 1), -1, 1'b0, 1'b0, added);
      end else if (r < 93) begin
        add_frame($urandom_range(1, MIN_SYMBOLS - 1), -1, 1'b0, 1'b1, added);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_symbol($urandom_range(MAX_TICKS), $urandom_range(MAX_TICKS),
                      $urandom_range(9) < 3, $urandom_range(9) < 3, added);
      end
    end
  endtask

  initial begin
    int added;
    added = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 15;
    stall_pct = 15;

    // directed, reset register values
    push_symbol(0, 0, 1'b1, 1'b1, added);
    push_symbol(MAX_TICKS, MAX_TICKS, 1'b1, 1'b1, added);
    push_symbol(9000, 4500, 1'b1, 1'b1, added);
    push_symbol(9000, 4500, 1'b0, 1'b0, added);
    push_symbol(560, 1690, 1'b0, 1'b1, added);
    push_symbol(6750, 4500, 1'b1, 1'b0, added);
    push_symbol(9000, 4500, 1'b1, 1'b0, added);
    push_symbol(560, 560, 1'b0, 1'b0, added);
    push_symbol(11249, 5624, 1'b1, 1'b1, added);
    push_symbol(6751, 3376, 1'b1, 1'b0, added);
    push_symbol(0, MAX_TICKS, 1'b0, 1'b0, added);
    push_symbol(MAX_TICKS, 0, 1'b0, 1'b1, added);
    fill_phase(100);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(1, 9000, 4500, 560, 560, 1690);
        1: apply_setting(10, 9000, 4500, 560, 560, 1690);
        2: apply_setting(16, $urandom_range(1000, 65535), $urandom_range(1000, 65535),
                         $urandom_range(200, 5000), $urandom_range(200, 5000),
                         $urandom_range(200, 5000));
        3: apply_setting(0, 9000, 4500, 560, 560, 1690);
        4: apply_setting(31, 65535, 65535, 65535, 65535, 65535);
        5: apply_setting(1, 0, 4500, 560, 0, 1690);
        6: apply_setting($urandom_range(1, 16), $urandom_range(200, 20000),
                         $urandom_range(200, 20000), $urandom_range(200, 20000),
                         $urandom_range(200, 20000), $urandom_range(200, 20000));
        default: apply_setting(2, 9000, 4500, 560, 560, 1690);
      endcase
      case (p)
        1: begin gap_pct = 0; stall_pct = 0; end
        4: begin gap_pct = 40; stall_pct = 40; end
        7: begin gap_pct = 0; stall_pct = 0; end
        default: begin gap_pct = 15; stall_pct = 20; end
      endcase
      fill_phase((p == 3) ? 60 : 160);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
